/* src/trfp_pkg.sv */
// Shared types, codes and character helpers for the text record frame parser.
`timescale 1ns / 1ps
`default_nettype none

package trfp_pkg;

    localparam int RX_W       = 8;
    localparam int EVENT_W    = 4;
    localparam int RECIDX_W   = 5;
    localparam int TAG_LEN    = 8;

    localparam logic [RX_W-1:0] CH_COLON = 8'h3A;
    localparam logic [RX_W-1:0] CH_TAB   = 8'h09;
    localparam logic [RX_W-1:0] CH_LF    = 8'h0A;
    localparam logic [RX_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE          = 4'd0,
        EV_NAME_CHAR     = 4'd1,
        EV_VALUE_CHAR    = 4'd2,
        EV_NAME_END      = 4'd3,
        EV_NAME_TRUNC    = 4'd4,
        EV_CHECKSUM_TAG  = 4'd5,
        EV_RECORD        = 4'd6,
        EV_VALUE_LONG    = 4'd7,
        EV_FRAME_FULL    = 4'd8,
        EV_FRAME_VALID   = 4'd9,
        EV_FRAME_INVALID = 4'd10,
        EV_HEX_BEGIN     = 4'd11,
        EV_HEX_END       = 4'd12
    } event_t;

    typedef enum logic [5:0] {
        M_IDLE   = 6'b000001,
        M_BEGIN  = 6'b000010,
        M_NAME   = 6'b000100,
        M_VALUE  = 6'b001000,
        M_CKBYTE = 6'b010000,
        M_HEX    = 6'b100000
    } mode_t;

    typedef struct packed {
        event_t                ev;
        logic [RX_W-1:0]       ch;
        logic [RECIDX_W-1:0]   idx;
        logic                  mid;
    } result_t;

    function automatic logic [RX_W-1:0] upcase(input logic [RX_W-1:0] c);
        logic [RX_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    function automatic logic [RX_W-1:0] tag_char(input logic [2:0] i);
        logic [RX_W-1:0] r;
        unique case (i)
            3'd0: r = 8'h43; // C
            3'd1: r = 8'h48; // H
            3'd2: r = 8'h45; // E
            3'd3: r = 8'h43; // C
            3'd4: r = 8'h4B; // K
            3'd5: r = 8'h53; // S
            3'd6: r = 8'h55; // U
            3'd7: r = 8'h4D; // M
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/trfp_core.sv */
// Next-state and event logic for one received byte.
`timescale 1ns / 1ps
`default_nettype none

module trfp_core
    import trfp_pkg::*;
#(
    parameter int NAME_MAX_LEN  = 9,
    parameter int VALUE_MAX_LEN = 33,
    parameter int FRAME_RECORDS = 22,
    localparam int NW = $clog2(NAME_MAX_LEN + 1),
    localparam int VW = $clog2(VALUE_MAX_LEN + 1),
    localparam int RW = $clog2(FRAME_RECORDS + 1)
)
(
    input  wire logic            enable,
    input  wire logic [RX_W-1:0] raw,
    input  wire mode_t           mode,
    input  wire logic [7:0]      sum,
    input  wire logic [NW-1:0]   name_len,
    input  wire logic [VW-1:0]   value_len,
    input  wire logic            tag,
    input  wire logic [RW-1:0]   recs,
    output mode_t                mode_next,
    output logic [7:0]           sum_next,
    output logic [NW-1:0]        name_len_next,
    output logic [VW-1:0]        value_len_next,
    output logic                 tag_next,
    output logic [RW-1:0]        recs_next,
    output result_t              res
);

    mode_t           mode_eff;
    logic [RX_W-1:0] c;

    always_comb
    begin
        mode_eff       = mode;
        mode_next      = mode;
        sum_next       = sum;
        name_len_next  = name_len;
        value_len_next = value_len;
        tag_next       = tag;
        recs_next      = recs;
        res            = '0;
        c              = upcase(raw);

        if (enable)
        begin
            // A colon starts a hex message anywhere except as the checksum byte or inside a hex message.
            if (raw == CH_COLON && mode != M_CKBYTE)
            begin
                if (mode != M_HEX)
                begin
                    res.ev  = EV_HEX_BEGIN;
                    res.mid = (recs != '0) || (mode != M_IDLE);
                end
                mode_eff = M_HEX;
            end
            if (mode_eff != M_HEX)
            begin
                sum_next = sum + raw;
            end
            mode_next = mode_eff;

            unique case (mode_eff)
                M_IDLE:
                begin
                    if (c == CH_LF)
                    begin
                        mode_next = M_BEGIN;
                    end
                end
                M_BEGIN:
                begin
                    name_len_next = NW'(1);
                    tag_next      = (c == tag_char(3'd0));
                    res.ev        = EV_NAME_CHAR;
                    res.ch        = c;
                    mode_next     = M_NAME;
                end
                M_NAME:
                begin
                    if (c == CH_TAB)
                    begin
                        if (name_len < NW'(NAME_MAX_LEN) && tag && name_len == NW'(TAG_LEN))
                        begin
                            res.ev    = EV_CHECKSUM_TAG;
                            mode_next = M_CKBYTE;
                        end
                        else
                        begin
                            res.ev = (name_len < NW'(NAME_MAX_LEN)) ? EV_NAME_END
                                                                    : EV_NAME_TRUNC;
                            value_len_next = '0;
                            mode_next      = M_VALUE;
                        end
                    end
                    else if (name_len < NW'(NAME_MAX_LEN))
                    begin
                        if (!(name_len < NW'(TAG_LEN) && c == tag_char(name_len[2:0])))
                        begin
                            tag_next = 1'b0;
                        end
                        name_len_next = name_len + NW'(1);
                        res.ev        = EV_NAME_CHAR;
                        res.ch        = c;
                    end
                end
                M_VALUE:
                begin
                    if (c == CH_LF)
                    begin
                        if (value_len >= VW'(VALUE_MAX_LEN))
                        begin
                            res.ev = EV_VALUE_LONG;
                        end
                        else if (recs < RW'(FRAME_RECORDS))
                        begin
                            res.ev    = EV_RECORD;
                            res.idx   = RECIDX_W'(recs);
                            recs_next = recs + RW'(1);
                        end
                        else
                        begin
                            res.ev = EV_FRAME_FULL;
                        end
                        mode_next = M_BEGIN;
                    end
                    else if (c != CH_CR && value_len < VW'(VALUE_MAX_LEN))
                    begin
                        value_len_next = value_len + VW'(1);
                        res.ev         = EV_VALUE_CHAR;
                        res.ch         = c;
                    end
                end
                M_CKBYTE:
                begin
                    res.ev    = (sum_next == 8'd0) ? EV_FRAME_VALID : EV_FRAME_INVALID;
                    sum_next  = 8'd0;
                    recs_next = '0;
                    mode_next = M_IDLE;
                end
                M_HEX:
                begin
                    if (c == CH_LF)
                    begin
                        res.ev    = EV_HEX_END;
                        sum_next  = 8'd0;
                        recs_next = '0;
                        mode_next = M_IDLE;
                    end
                end
                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/trfp_outbuf.sv */
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
`default_nettype none

module trfp_outbuf
    import trfp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    take;

    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // No request is taken while the skid register holds a result.
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* src/text_record_frame_parser.sv */
// Text record frame parser top level: parser state, enable register and result buffer.
// An accepted byte's event is registered in the output register, or in the skid register while the output stalls.
// Throughput: one byte per cycle while in_stall is low; the parser state updates on every accepted byte.
// A two-entry result buffer lets one more byte in while a result is stalled.
// Reset: asynchronous, active low; parser idle, sums and counts zero,
// enable register set, result buffer empty.
`timescale 1ns / 1ps
`default_nettype none

module text_record_frame_parser
    import trfp_pkg::*;
#(
    parameter int NAME_MAX_LEN  = 9,
    parameter int VALUE_MAX_LEN = 33,
    parameter int FRAME_RECORDS = 22
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic                cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [RX_W-1:0]     rx_byte,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [EVENT_W-1:0]       event_res,
    output logic [RX_W-1:0]          char_out,
    output logic [RECIDX_W-1:0]      record_index,
    output logic                     hex_mid_frame
);

    localparam int NW = $clog2(NAME_MAX_LEN + 1);
    localparam int VW = $clog2(VALUE_MAX_LEN + 1);
    localparam int RW = $clog2(FRAME_RECORDS + 1);

    logic          enable_reg;
    mode_t         mode_reg;
    mode_t         mode_next;
    logic [7:0]    sum_reg;
    logic [7:0]    sum_next;
    logic [NW-1:0] name_len_reg;
    logic [NW-1:0] name_len_next;
    logic [VW-1:0] value_len_reg;
    logic [VW-1:0] value_len_next;
    logic          tag_reg;
    logic          tag_next;
    logic [RW-1:0] recs_reg;
    logic [RW-1:0] recs_next;
    result_t       step_res;
    result_t       out_res;
    logic          accept;
    logic          buf_full;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    trfp_core #(
        .NAME_MAX_LEN  (NAME_MAX_LEN),
        .VALUE_MAX_LEN (VALUE_MAX_LEN),
        .FRAME_RECORDS (FRAME_RECORDS)
    ) u_core (
        .enable         (enable_reg),
        .raw            (rx_byte),
        .mode           (mode_reg),
        .sum            (sum_reg),
        .name_len       (name_len_reg),
        .value_len      (value_len_reg),
        .tag            (tag_reg),
        .recs           (recs_reg),
        .mode_next      (mode_next),
        .sum_next       (sum_next),
        .name_len_next  (name_len_next),
        .value_len_next (value_len_next),
        .tag_next       (tag_next),
        .recs_next      (recs_next),
        .res            (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            mode_reg      <= M_IDLE;
            sum_reg       <= '0;
            name_len_reg  <= '0;
            value_len_reg <= '0;
            tag_reg       <= 1'b0;
            recs_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                enable_reg <= cfg_data;
            end
            if (accept)
            begin
                mode_reg      <= mode_next;
                sum_reg       <= sum_next;
                name_len_reg  <= name_len_next;
                value_len_reg <= value_len_next;
                tag_reg       <= tag_next;
                recs_reg      <= recs_next;
            end
        end
    end

    trfp_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign event_res     = out_res.ev;
    assign char_out      = out_res.ch;
    assign record_index  = out_res.idx;
    assign hex_mid_frame = out_res.mid;

    // The skid register is only ever filled behind a waiting output register.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("skid register holds a result while the output is empty");

    assert property (@(posedge clk) disable iff (!rst_n) recs_reg <= RW'(FRAME_RECORDS))
        else $error("record count exceeds the frame limit");

    assert property (@(posedge clk) disable iff (!rst_n) name_len_reg <= NW'(NAME_MAX_LEN))
        else $error("name length exceeds its limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == EV_RECORD) |-> (record_index < RECIDX_W'(FRAME_RECORDS)))
        else $error("record index out of range");

endmodule

`default_nettype wire

/* dv/tb_text_record_frame_parser.sv */
// Self-checking testbench for the text record frame parser: directed and random byte streams.
`timescale 1ns / 1ps

module tb_text_record_frame_parser;
    import trfp_pkg::*;

    localparam int NAME_LIMIT   = 9;
    localparam int VALUE_LIMIT  = 33;
    localparam int RECORD_LIMIT = 22;
    localparam int IDLE_PCT     = 19;
    localparam int MAIN_BYTES   = 1200;
    // Queue codes above the byte range stand for a checksum byte that is
    // worked out from the running sum when the request is presented.
    localparam int CK_GOOD = 256;
    localparam int CK_BAD  = 257;
    localparam logic [79:0] NEAR_TAG = "CHECKSUMXY";

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic                cfg_data = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [RX_W-1:0]     rx_byte = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [EVENT_W-1:0]  event_res;
    logic [RX_W-1:0]     char_out;
    logic [RECIDX_W-1:0] record_index;
    logic                hex_mid_frame;

    // Parser state as the block should hold it.
    mode_t       mode_q = M_IDLE;
    logic [7:0]  sum_q = 8'h00;
    logic [3:0]  name_len_q = '0;
    logic [5:0]  val_len_q = '0;
    logic        tag_hit_q = 1'b0;
    logic [4:0]  recs_q = '0;
    logic        rx_on = 1'b1;

    int      tx_bytes[$];
    result_t expected_events[$];
    result_t want;
    int      errors = 0;
    int      queued = 0;
    int      taken = 0;
    int      cyc = 0;
    int      code;

    // Both sides run without gaps for a while in the middle of the run.
    wire steady = (cyc >= 600) && (cyc < 1400);

    text_record_frame_parser #(
        .NAME_MAX_LEN  (NAME_LIMIT),
        .VALUE_MAX_LEN (VALUE_LIMIT),
        .FRAME_RECORDS (RECORD_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .char_out      (char_out),
        .record_index  (record_index),
        .hex_mid_frame (hex_mid_frame)
    );

    always #2 clk = ~clk;

    function automatic logic [7:0] tag_text_at(input int i);
        return NEAR_TAG[8 * (9 - i) +: 8];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want_v);
        errors++;
    endtask

    task automatic predict_event(input logic [7:0] raw);
        logic [7:0] c;
        result_t    r;
        r.ev  = EV_NONE;
        r.ch  = 8'h00;
        r.idx = '0;
        r.mid = 1'b0;
        if (rx_on)
        begin
            if (raw == CH_COLON && mode_q != M_CKBYTE)
            begin
                if (mode_q != M_HEX)
                begin
                    r.ev  = EV_HEX_BEGIN;
                    r.mid = (recs_q != 0) || (mode_q != M_IDLE);
                end
                mode_q = M_HEX;
            end
            if (mode_q != M_HEX)
                sum_q = sum_q + raw;
            c = (raw >= 8'h61 && raw <= 8'h7A) ? raw - 8'd32 : raw;
            case (mode_q)
                M_IDLE:
                begin
                    if (c == CH_LF)
                        mode_q = M_BEGIN;
                end
                M_BEGIN:
                begin
                    name_len_q = 1;
                    tag_hit_q  = (c == tag_text_at(0));
                    r.ev       = EV_NAME_CHAR;
                    r.ch       = c;
                    mode_q     = M_NAME;
                end
                M_NAME:
                begin
                    if (c == CH_TAB)
                    begin
                        if (name_len_q < NAME_LIMIT && tag_hit_q && name_len_q == TAG_LEN)
                        begin
                            r.ev   = EV_CHECKSUM_TAG;
                            mode_q = M_CKBYTE;
                        end
                        else
                        begin
                            if (name_len_q < NAME_LIMIT)
                                r.ev = EV_NAME_END;
                            else
                                r.ev = EV_NAME_TRUNC;
                            val_len_q = 0;
                            mode_q    = M_VALUE;
                        end
                    end
                    else if (name_len_q < NAME_LIMIT)
                    begin
                        if (!(name_len_q < TAG_LEN && c == tag_text_at(name_len_q)))
                            tag_hit_q = 1'b0;
                        name_len_q++;
                        r.ev = EV_NAME_CHAR;
                        r.ch = c;
                    end
                end
                M_VALUE:
                begin
                    if (c == CH_LF)
                    begin
                        if (val_len_q >= VALUE_LIMIT)
                            r.ev = EV_VALUE_LONG;
                        else if (recs_q < RECORD_LIMIT)
                        begin
                            r.ev  = EV_RECORD;
                            r.idx = recs_q;
                            recs_q++;
                        end
                        else
                            r.ev = EV_FRAME_FULL;
                        mode_q = M_BEGIN;
                    end
                    else if (c != CH_CR && val_len_q < VALUE_LIMIT)
                    begin
                        val_len_q++;
                        r.ev = EV_VALUE_CHAR;
                        r.ch = c;
                    end
                end
                M_CKBYTE:
                begin
                    if (sum_q == 8'h00)
                        r.ev = EV_FRAME_VALID;
                    else
                        r.ev = EV_FRAME_INVALID;
                    sum_q  = 8'h00;
                    recs_q = '0;
                    mode_q = M_IDLE;
                end
                M_HEX:
                begin
                    if (c == CH_LF)
                    begin
                        r.ev   = EV_HEX_END;
                        sum_q  = 8'h00;
                        recs_q = '0;
                        mode_q = M_IDLE;
                    end
                end
                default: mode_q = M_IDLE;
            endcase
        end
        expected_events.push_back(r);
    endtask

    // Request side: presents queued bytes, predicts each accepted one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_event(rx_byte);
                taken++;
            end
            if (cfg_write)
                rx_on = cfg_data;
            if (!in_valid || !in_stall)
            begin
                if (tx_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    code = tx_bytes.pop_front();
                    in_valid <= 1'b1;
                    case (code)
                        CK_GOOD: rx_byte <= 8'h00 - sum_q;
                        CK_BAD:  rx_byte <= 8'h01 - sum_q;
                        default: rx_byte <= code[7:0];
                    endcase
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: random stalls and field-by-field comparison.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    report_mismatch("unexpected result, event_res", event_res, -1);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_res !== want.ev)
                        report_mismatch("event_res", event_res, want.ev);
                    if (char_out !== want.ch)
                        report_mismatch("char_out", char_out, want.ch);
                    if (record_index !== want.idx)
                        report_mismatch("record_index", record_index, want.idx);
                    if (hex_mid_frame !== want.mid)
                        report_mismatch("hex_mid_frame", hex_mid_frame, want.mid);
                end
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic queue_byte(input int b);
        tx_bytes.push_back(b);
        queued++;
    endtask

    function automatic logic [7:0] pick_char(input bit in_value);
        logic [7:0] b;
        case ($urandom_range(9))
            0, 1, 2, 3: b = $urandom_range(8'h5A, 8'h41);
            4, 5:       b = $urandom_range(8'h7A, 8'h61);
            6:          b = $urandom_range(8'h39, 8'h30);
            7:          b = in_value ? CH_CR : 8'h5F;
            default:
            begin
                b = $urandom_range(255);
                while (b == CH_LF || b == CH_COLON || (!in_value && b == CH_TAB))
                    b = $urandom_range(255);
            end
        endcase
        return b;
    endfunction

    task automatic queue_hex();
        queue_byte(CH_COLON);
        repeat ($urandom_range(12))
        begin
            if ($urandom_range(7) == 0)
                queue_byte(CH_COLON);
            else
                queue_byte(pick_char(1'b1));
        end
        queue_byte(CH_LF);
    endtask

    task automatic queue_record(input bit crowded);
        int nlen;
        int vlen;
        int i;
        bit near;
        near = 1'b0;
        if (crowded)
            nlen = $urandom_range(3, 1);
        else
        begin
            case ($urandom_range(5))
                3: nlen = $urandom_range(NAME_LIMIT + 4, NAME_LIMIT - 1);
                4:
                begin
                    near = 1'b1;
                    nlen = $urandom_range(10, 1);
                end
                default: nlen = $urandom_range(8, 1);
            endcase
        end
        for (i = 0; i < nlen; i++)
        begin
            if (near)
                queue_byte(tag_text_at(i) | ($urandom_range(1) ? 8'h20 : 8'h00));
            else
                queue_byte(pick_char(1'b0));
        end
        queue_byte(CH_TAB);
        if (crowded)
            vlen = $urandom_range(2);
        else if ($urandom_range(5) == 0)
            vlen = $urandom_range(VALUE_LIMIT + 5, VALUE_LIMIT - 2);
        else
            vlen = $urandom_range(10);
        for (i = 0; i < vlen; i++)
        begin
            // Now and then a hex message breaks into the value.
            if ($urandom_range(49) == 0)
            begin
                queue_hex();
                return;
            end
            queue_byte(pick_char(1'b1));
        end
        queue_byte(CH_LF);
    endtask

    task automatic queue_frame();
        int nrec;
        int i;
        bit crowded;
        crowded = ($urandom_range(14) == 0);
        nrec = crowded ? $urandom_range(RECORD_LIMIT + 3, RECORD_LIMIT - 2) : $urandom_range(6);
        queue_byte(CH_LF);
        repeat (nrec) queue_record(crowded);
        case ($urandom_range(9))
            8: queue_hex();
            9: ;
            default:
            begin
                for (i = 0; i < TAG_LEN; i++)
                    queue_byte(tag_text_at(i) | ($urandom_range(1) ? 8'h20 : 8'h00));
                queue_byte(CH_TAB);
                case ($urandom_range(7))
                    0:       queue_byte($urandom_range(255));
                    1, 2:    queue_byte(CK_BAD);
                    default: queue_byte(CK_GOOD);
                endcase
            end
        endcase
    endtask

    task automatic wait_drained();
        int n;
        while (taken < queued)
            @(posedge clk);
        n = 0;
        while (expected_events.size() != 0 && n < 500)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    task automatic set_receive(input logic on);
        wait_drained();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= on;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int i;
        int start;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Byte extremes while idle, then one short record.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CH_LF);
        queue_byte("a");
        queue_byte(CH_TAB);
        queue_byte("z");
        queue_byte(CH_CR);
        queue_byte(CH_LF);
        // Lower-case checksum tag with a correct checksum byte.
        for (i = 0; i < TAG_LEN; i++)
            queue_byte(tag_text_at(i) | 8'h20);
        queue_byte(CH_TAB);
        queue_byte(CK_GOOD);
        // Hex message from idle, with a second colon as payload.
        queue_byte(CH_COLON);
        queue_byte(CH_COLON);
        queue_byte(CH_LF);
        // A tab right after the newline is a name character; hex then aborts.
        queue_byte(CH_LF);
        queue_byte(CH_TAB);
        queue_byte(CH_COLON);
        queue_byte(CH_LF);

        set_receive(1'b0);
        repeat (40) queue_byte($urandom_range(255));
        set_receive(1'b1);

        start = queued;
        while (queued - start < MAIN_BYTES)
        begin
            case ($urandom_range(9))
                7: queue_hex();
                8, 9:
                begin
                    repeat ($urandom_range(4, 1)) queue_byte($urandom_range(255));
                end
                default: queue_frame();
            endcase
        end

        // Disabling in the middle of whatever state was left must keep it.
        set_receive(1'b0);
        repeat (30) queue_byte($urandom_range(255));
        set_receive(1'b1);
        repeat (3) queue_frame();

        wait_drained();
        repeat (4) @(posedge clk);
        if (expected_events.size() != 0)
            report_mismatch("results never seen, count", expected_events.size(), 0);
        if (errors == 0)
            $display("tb_text_record_frame_parser: clean");
        else
            $display("tb_text_record_frame_parser: errors");
        $finish;
    end

    initial
    begin
        #(4_000_000);
        $display("tb_text_record_frame_parser: errors");
        $finish;
    end

endmodule
